// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tcw_pkg
// Shared types, codes and reset constants of the text console writer.
// ============================================================================
package tcw_pkg;

    // Video memory size in cells; offsets wrap at this size
    localparam int          ADDR_W    = 14;
    localparam logic [14:0] MEM_CELLS = 15'd16384;

    // Command kinds on the result channel
    localparam logic [2:0] KIND_WRITE  = 3'd0;
    localparam logic [2:0] KIND_COPY   = 3'd1;
    localparam logic [2:0] KIND_FILL   = 3'd2;
    localparam logic [2:0] KIND_ORIGIN = 3'd3;
    localparam logic [2:0] KIND_CURSOR = 3'd4;

    // Result slots of one byte, in the order they leave the block
    localparam int NUM_SLOTS   = 5;
    localparam int SLOT_COPY   = 0;
    localparam int SLOT_FILL   = 1;
    localparam int SLOT_ORIGIN = 2;
    localparam int SLOT_WRITE  = 3;
    localparam int SLOT_CURSOR = 4;

    // Configuration register indexes
    localparam logic [2:0] REG_COLUMNS      = 3'd0;
    localparam logic [2:0] REG_LINES        = 3'd1;
    localparam logic [2:0] REG_WINDOW_CELLS = 3'd2;
    localparam logic [2:0] REG_ATTRIBUTE    = 3'd3;
    localparam logic [2:0] REG_ERASE_CELL   = 3'd4;
    localparam logic [2:0] REG_NEWLINE_MODE = 3'd5;

    // Newline modes
    localparam logic NL_TTY   = 1'b0;
    localparam logic NL_PRINT = 1'b1;

    // Character codes
    localparam logic [7:0] CH_LF        = 8'd10;
    localparam logic [7:0] CH_VT        = 8'd11;
    localparam logic [7:0] CH_FF        = 8'd12;
    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_CTRL_LAST = 8'd31;
    localparam logic [7:0] CH_DEL       = 8'd127;

    // Register reset values
    localparam logic [7:0]  RST_COLUMNS      = 8'd80;
    localparam logic [7:0]  RST_LINES        = 8'd25;
    localparam logic [14:0] RST_WINDOW_CELLS = 15'd4096;
    localparam logic [7:0]  RST_ATTRIBUTE    = 8'h07;
    localparam logic [15:0] RST_ERASE_CELL   = 16'h0720;

    // Geometry derived from the reset values
    localparam logic [15:0] RST_SCREEN = 16'(80 * 25);
    localparam logic [15:0] RST_BODY   = 16'(80 * 24);

    typedef struct packed {
        logic [7:0]  columns;
        logic [7:0]  lines;
        logic [14:0] window_cells;
        logic [7:0]  attribute;
        logic [15:0] erase_cell;
        logic        newline_mode;
    } cfg_t;

    // Configuration-only products, held in registers
    typedef struct packed {
        logic [7:0]  cols;      // columns, zero read as one
        logic [7:0]  lines;     // lines, zero read as one
        logic [15:0] screen;    // lines * cols
        logic [15:0] body;      // (lines - 1) * cols
        logic [14:0] copy_cnt;  // body, saturated at memory size
        logic [14:0] win;       // window, limited to memory size
    } geom_t;

    typedef struct packed {
        logic [7:0]        col;
        logic [7:0]        row;
        logic [ADDR_W-1:0] origin;
    } state_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] source;
        logic [14:0]       count;
        logic [15:0]       cell_value;
    } result_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]         valid;
        result_t [NUM_SLOTS-1:0]      slot;
    } bank_t;

endpackage

// ===== rtl/tcw_geom.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tcw_geom
// Registers the screen geometry products that depend on configuration only.
// ============================================================================
module tcw_geom (
    input  logic           clk,
    input  logic           rst_n,
    input  tcw_pkg::cfg_t  cfg,
    output tcw_pkg::geom_t geom
);

    tcw_pkg::geom_t geom_reg;
    tcw_pkg::geom_t geom_next;

    // Clamp zero sizes, form screen, body, copy count and window sizes
    always_comb
    begin
        geom_next.cols   = (cfg.columns == 8'd0) ? 8'd1 : cfg.columns;
        geom_next.lines  = (cfg.lines == 8'd0) ? 8'd1 : cfg.lines;
        geom_next.screen = {8'd0, geom_next.lines} * {8'd0, geom_next.cols};
        geom_next.body   = geom_next.screen - {8'd0, geom_next.cols};
        geom_next.copy_cnt = (geom_next.body > {1'b0, tcw_pkg::MEM_CELLS})
                           ? tcw_pkg::MEM_CELLS : geom_next.body[14:0];
        geom_next.win    = (cfg.window_cells > tcw_pkg::MEM_CELLS)
                           ? tcw_pkg::MEM_CELLS : cfg.window_cells;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.cols     <= tcw_pkg::RST_COLUMNS;
            geom_reg.lines    <= tcw_pkg::RST_LINES;
            geom_reg.screen   <= tcw_pkg::RST_SCREEN;
            geom_reg.body     <= tcw_pkg::RST_BODY;
            geom_reg.copy_cnt <= tcw_pkg::RST_BODY[14:0];
            geom_reg.win      <= tcw_pkg::RST_WINDOW_CELLS;
        end
        else
        begin
            geom_reg <= geom_next;
        end
    end

    assign geom = geom_reg;

endmodule

// ===== rtl/tcw_step.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tcw_step
// Decodes one byte against the cursor state and forms the new state and
// every command the byte causes, one slot per command kind.
// ============================================================================
module tcw_step (
    input  tcw_pkg::state_t cur_state,
    input  tcw_pkg::geom_t  geom,
    input  logic [7:0]      attribute,
    input  logic [15:0]     erase_cell,
    input  logic            newline_mode,
    input  logic [7:0]      char_byte,
    input  logic            end_of_batch,
    output tcw_pkg::state_t next_state,
    output tcw_pkg::bank_t  bank
);

    logic        is_write;
    logic        is_lf;
    logic        is_cr;
    logic        col_wrap;
    logic        do_lf;
    logic        row_adv;
    logic        scroll;
    logic        win_over;
    logic [8:0]  row_p1;
    logic [7:0]  col1;
    logic [15:0] row_base;
    logic [15:0] row_base_new;
    logic [14:0] new_org;
    logic [16:0] screen_end;
    logic [tcw_pkg::ADDR_W-1:0] org_new;
    logic [tcw_pkg::ADDR_W-1:0] write_pos;
    logic [tcw_pkg::ADDR_W-1:0] cursor_pos;

    // Byte classes per newline mode
    always_comb
    begin
        if (newline_mode == tcw_pkg::NL_TTY)
        begin
            is_write = (char_byte > tcw_pkg::CH_CTRL_LAST) && (char_byte < tcw_pkg::CH_DEL);
            is_lf    = (char_byte == tcw_pkg::CH_LF) || (char_byte == tcw_pkg::CH_VT)
                    || (char_byte == tcw_pkg::CH_FF);
            is_cr    = (char_byte == tcw_pkg::CH_CR);
        end
        else
        begin
            is_lf    = (char_byte == tcw_pkg::CH_LF);
            is_cr    = (char_byte == tcw_pkg::CH_CR);
            is_write = !is_lf && !is_cr;
        end
    end

    // Column, line feed and scroll decisions
    always_comb
    begin
        col_wrap = is_write && (cur_state.col >= geom.cols);
        do_lf    = is_lf || col_wrap;
        row_p1   = {1'b0, cur_state.row} + 9'd1;
        row_adv  = do_lf && (row_p1 < {1'b0, geom.lines});
        scroll   = do_lf && !row_adv;

        // print rules return the carriage on line feed as well
        if (is_cr || (is_lf && newline_mode == tcw_pkg::NL_PRINT))
            col1 = 8'd0;
        else if (col_wrap)
            col1 = cur_state.col - geom.cols;
        else
            col1 = cur_state.col;

        row_base     = {8'd0, cur_state.row} * {8'd0, geom.cols};
        row_base_new = row_adv ? (row_base + {8'd0, geom.cols}) : row_base;

        new_org    = {1'b0, cur_state.origin} + {7'd0, geom.cols};
        screen_end = {2'd0, new_org} + {1'b0, geom.screen};
        win_over   = screen_end > {2'd0, geom.win};

        if (scroll)
            org_new = win_over ? '0 : new_org[tcw_pkg::ADDR_W-1:0];
        else
            org_new = cur_state.origin;

        write_pos  = org_new + row_base_new[tcw_pkg::ADDR_W-1:0]
                   + {{(tcw_pkg::ADDR_W-8){1'b0}}, col1};
        cursor_pos = write_pos + {{(tcw_pkg::ADDR_W-1){1'b0}}, is_write};

        next_state.col    = col1 + {7'd0, is_write};
        next_state.row    = row_adv ? row_p1[7:0] : cur_state.row;
        next_state.origin = org_new;
    end

    // Command slots
    always_comb
    begin
        bank = '0;

        bank.valid[tcw_pkg::SLOT_COPY]          = scroll && win_over;
        bank.slot[tcw_pkg::SLOT_COPY].kind      = tcw_pkg::KIND_COPY;
        bank.slot[tcw_pkg::SLOT_COPY].source    = new_org[tcw_pkg::ADDR_W-1:0];
        bank.slot[tcw_pkg::SLOT_COPY].count     = geom.copy_cnt;

        bank.valid[tcw_pkg::SLOT_FILL]          = scroll;
        bank.slot[tcw_pkg::SLOT_FILL].kind      = tcw_pkg::KIND_FILL;
        bank.slot[tcw_pkg::SLOT_FILL].address   = win_over
            ? geom.body[tcw_pkg::ADDR_W-1:0]
            : new_org[tcw_pkg::ADDR_W-1:0] + geom.body[tcw_pkg::ADDR_W-1:0];
        bank.slot[tcw_pkg::SLOT_FILL].count     = {7'd0, geom.cols};
        bank.slot[tcw_pkg::SLOT_FILL].cell_value = erase_cell;

        bank.valid[tcw_pkg::SLOT_ORIGIN]        = scroll;
        bank.slot[tcw_pkg::SLOT_ORIGIN].kind    = tcw_pkg::KIND_ORIGIN;
        bank.slot[tcw_pkg::SLOT_ORIGIN].address = org_new;

        bank.valid[tcw_pkg::SLOT_WRITE]         = is_write;
        bank.slot[tcw_pkg::SLOT_WRITE].kind     = tcw_pkg::KIND_WRITE;
        bank.slot[tcw_pkg::SLOT_WRITE].address  = write_pos;
        bank.slot[tcw_pkg::SLOT_WRITE].count    = 15'd1;
        bank.slot[tcw_pkg::SLOT_WRITE].cell_value = {attribute, char_byte};

        bank.valid[tcw_pkg::SLOT_CURSOR]        = end_of_batch;
        bank.slot[tcw_pkg::SLOT_CURSOR].kind    = tcw_pkg::KIND_CURSOR;
        bank.slot[tcw_pkg::SLOT_CURSOR].address = cursor_pos;
    end

endmodule

// ===== rtl/tcw_drain.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tcw_drain
// Result bank: holds the commands of one byte and sends them one word per
// cycle while m_tready is high, lowest slot first, marking the final one.
// ============================================================================
module tcw_drain (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  tcw_pkg::bank_t   bank,
    input  logic             m_tready,
    output logic             m_tvalid,
    output tcw_pkg::result_t word,
    output logic             word_last,
    output logic             free
);

    logic [tcw_pkg::NUM_SLOTS-1:0] valid_reg;
    logic [tcw_pkg::NUM_SLOTS-1:0] valid_next;
    logic [tcw_pkg::NUM_SLOTS-1:0] sel;
    logic [tcw_pkg::NUM_SLOTS-1:0] rest;
    logic                          take;
    tcw_pkg::result_t [tcw_pkg::NUM_SLOTS-1:0] slot_reg;

    // Lowest pending slot goes out first
    assign sel       = valid_reg & (~valid_reg + tcw_pkg::NUM_SLOTS'(1));
    assign rest      = valid_reg & ~sel;
    assign m_tvalid  = (valid_reg != '0);
    assign take      = m_tvalid && m_tready;
    assign word_last = (rest == '0);
    assign free      = !m_tvalid || (word_last && m_tready);

    always_comb
    begin
        word = '0;
        for (int i = 0; i < tcw_pkg::NUM_SLOTS; i++)
        begin
            if (sel[i])
                word = word | slot_reg[i];
        end
    end

    // Pending mask
    always_comb
    begin
        if (load)
            valid_next = bank.valid;
        else if (take)
            valid_next = rest;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Command payloads
    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= bank.slot;
    end

endmodule

// ===== rtl/text_console_writer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// text_console_writer
// Text console cursor, origin and scroll control with a command output.
// ============================================================================
// Each byte on the slave stream is a character or control code; the block
// answers with video memory and display commands on the master stream (write
// cell, copy block, fill row, set origin, set cursor), tlast on the final
// command of a byte. A byte is registered on accept, decoded and resolved
// from that register and its commands go into a five-slot result bank that
// sends one word per cycle while m_tready is high. A byte that gives at most
// one command is followed by the next one every cycle while m_tready is high;
// a byte with more holds the input until its final command is taken, since
// all commands leave through the one output port; a character that wraps and
// scrolls past the window end at the end of a batch gives all five. Writes to
// configuration are registered, geometry again in tcw_geom; the user must
// make them only while the block is idle; the block does not enforce this.
// ============================================================================
module text_console_writer (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // end_of_batch
    // command output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [13:0] address, [27:14] source,
                                   // [42:28] count, [58:43] cell_value
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // last
);

    tcw_pkg::cfg_t    cfg_reg;
    tcw_pkg::cfg_t    cfg_next;
    tcw_pkg::geom_t   geom;
    tcw_pkg::state_t  state_reg;
    tcw_pkg::state_t  state_next;
    tcw_pkg::bank_t   step_bank;
    tcw_pkg::result_t out_word;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_eob_reg;
    logic       bank_free;
    logic       load;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tcw_pkg::REG_COLUMNS:      cfg_next.columns      = cfg_data[7:0];
                tcw_pkg::REG_LINES:        cfg_next.lines        = cfg_data[7:0];
                tcw_pkg::REG_WINDOW_CELLS: cfg_next.window_cells = cfg_data[14:0];
                tcw_pkg::REG_ATTRIBUTE:    cfg_next.attribute    = cfg_data[7:0];
                tcw_pkg::REG_ERASE_CELL:   cfg_next.erase_cell   = cfg_data;
                tcw_pkg::REG_NEWLINE_MODE: cfg_next.newline_mode = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns      <= tcw_pkg::RST_COLUMNS;
            cfg_reg.lines        <= tcw_pkg::RST_LINES;
            cfg_reg.window_cells <= tcw_pkg::RST_WINDOW_CELLS;
            cfg_reg.attribute    <= tcw_pkg::RST_ATTRIBUTE;
            cfg_reg.erase_cell   <= tcw_pkg::RST_ERASE_CELL;
            cfg_reg.newline_mode <= tcw_pkg::NL_TTY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tcw_geom u_geom (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .geom  (geom)
    );

    // Input word register
    assign load          = in_valid_reg && bank_free;
    assign s_tready      = !in_valid_reg || bank_free;
    assign in_valid_next = (s_tvalid && s_tready) ? 1'b1 : (load ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_eob_reg  <= s_tlast;
        end
    end

    tcw_step u_step (
        .cur_state    (state_reg),
        .geom         (geom),
        .attribute    (cfg_reg.attribute),
        .erase_cell   (cfg_reg.erase_cell),
        .newline_mode (cfg_reg.newline_mode),
        .char_byte    (in_char_reg),
        .end_of_batch (in_eob_reg),
        .next_state   (state_next),
        .bank         (step_bank)
    );

    // Cursor and origin state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (load)
            state_reg <= state_next;
    end

    tcw_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .bank      (step_bank),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .word      (out_word),
        .word_last (m_tlast),
        .free      (bank_free)
    );

    // Output packing
    assign m_tuser = out_word.kind;
    assign m_tdata = {5'd0, out_word.cell_value, out_word.count,
                      out_word.source, out_word.address};

    // Checks
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= tcw_pkg::KIND_CURSOR))
        else $error("command kind out of range");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("commands of a byte lost before its final word");

    a_copy_group: assert property (@(posedge clk) disable iff (!rst_n)
        (load && step_bank.valid[tcw_pkg::SLOT_COPY]) |->
        (step_bank.valid[tcw_pkg::SLOT_FILL] && step_bank.valid[tcw_pkg::SLOT_ORIGIN]))
        else $error("block copy without row fill and origin update");

    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (load && step_bank.valid[tcw_pkg::SLOT_ORIGIN]) |=>
        (state_reg.row == $past(state_reg.row)))
        else $error("cursor row moved on a scroll");

endmodule
